// ----- design/svlp_pkg.sv -----
// ----------------------------------------------------------------------------
// SSH version line parser package
// Shared types, character codes, tags and status codes.
// ----------------------------------------------------------------------------
package svlp_pkg;

    // Longest line tracked before the too-long status is raised
    localparam int MAX_LINE = 255;
    localparam int CNT_W    = $clog2(MAX_LINE + 1);

    typedef logic [CNT_W-1:0] cnt_t;

    localparam cnt_t MAX_CNT = CNT_W'(MAX_LINE);

    // Character codes
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_DASH  = 8'h2D;

    typedef enum logic [2:0] {
        PH_PREFIX  = 3'd0,
        PH_PROTO   = 3'd1,
        PH_SOFT    = 3'd2,
        PH_COMMENT = 3'd3,
        PH_TAIL    = 3'd4,
        PH_REJECT  = 3'd5
    } phase_t;

    typedef enum logic [2:0] {
        ST_RUN        = 3'd0,
        ST_OK         = 3'd1,
        ST_BAD_PREFIX = 3'd2,
        ST_NO_DASH    = 3'd3,
        ST_TOO_LONG   = 3'd4
    } status_t;

    typedef enum logic [3:0] {
        TAG_PREFIX   = 4'd0,
        TAG_PROTO    = 4'd1,
        TAG_DASH     = 4'd2,
        TAG_SOFTWARE = 4'd3,
        TAG_SPACE    = 4'd4,
        TAG_COMMENT  = 4'd5,
        TAG_CR       = 4'd6,
        TAG_LF       = 4'd7,
        TAG_IGNORED  = 4'd8
    } tag_t;

    // One received byte
    typedef struct packed {
        logic [7:0] data_byte;
        logic       last_byte;
    } in_item_t;

    // One result item
    typedef struct packed {
        tag_t       field_tag;
        logic       line_done;
        status_t    line_status;
        logic       version_ok;
        logic [7:0] protocol_len;
        logic [7:0] software_len;
        logic [7:0] comment_len;
        logic [7:0] line_len;
    } result_t;

    // Report a count on an 8-bit length field, clamped at 255
    function automatic logic [7:0] len8(input cnt_t v);
        len8 = (int'(v) > 255) ? 8'hFF : 8'(v);
    endfunction

endpackage

// ----- design/svlp_in_reg.sv -----
// ----------------------------------------------------------------------------
// SSH version line parser input register
// Holds one received item and hands it to the parser when it advances.
// ----------------------------------------------------------------------------
module svlp_in_reg (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_tvalid,
    output logic               s_tready,
    input  logic [7:0]         s_tdata,   // [7:0] data_byte
    input  logic               s_tlast,   // last_byte
    input  logic               take,
    output logic               item_valid,
    output svlp_pkg::in_item_t item
);

    logic               valid_reg;
    svlp_pkg::in_item_t item_reg;

    // Free when empty or when the held item moves on this cycle
    assign s_tready   = !valid_reg || take;
    assign item_valid = valid_reg;
    assign item       = item_reg;

    // Occupancy
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (s_tvalid && s_tready) begin
            valid_reg <= 1'b1;
        end else if (take) begin
            valid_reg <= 1'b0;
        end
    end

    // Payload
    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            item_reg.data_byte <= s_tdata;
            item_reg.last_byte <= s_tlast;
        end
    end

endmodule

// ----- design/svlp_parser.sv -----
// ----------------------------------------------------------------------------
// SSH version line parser core
// Per-byte phase machine with field counters and version matching.
// ----------------------------------------------------------------------------
module svlp_parser (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               advance,
    input  svlp_pkg::in_item_t item,
    output svlp_pkg::result_t  result
);

    svlp_pkg::phase_t  phase_reg, phase_next;
    svlp_pkg::status_t fail_reg, fail_next;
    logic [1:0]        vmatch_reg, vmatch_next;
    svlp_pkg::cnt_t    pos_reg, pos_next;
    svlp_pkg::cnt_t    proto_reg, proto_next;
    svlp_pkg::cnt_t    soft_reg, soft_next;
    svlp_pkg::cnt_t    comment_reg, comment_next;
    svlp_pkg::cnt_t    content_reg, content_next;

    logic             line_end;
    logic             closed;
    svlp_pkg::tag_t   tag;

    function automatic svlp_pkg::cnt_t sat_inc(input svlp_pkg::cnt_t v);
        sat_inc = (v == svlp_pkg::MAX_CNT) ? v : v + svlp_pkg::cnt_t'(1);
    endfunction

    // "SSH-"
    function automatic logic [7:0] prefix_char(input logic [1:0] i);
        case (i)
            2'd0:    prefix_char = 8'h53;
            2'd1:    prefix_char = 8'h53;
            2'd2:    prefix_char = 8'h48;
            default: prefix_char = svlp_pkg::CH_DASH;
        endcase
    endfunction

    // "2.0" (index 3 never matches)
    function automatic logic match_v20(input svlp_pkg::cnt_t i, input logic [7:0] b);
        case (i[1:0])
            2'd0:    match_v20 = (b == 8'h32);
            2'd1:    match_v20 = (b == 8'h2E);
            2'd2:    match_v20 = (b == 8'h30);
            default: match_v20 = 1'b0;
        endcase
        if (i >= svlp_pkg::cnt_t'(3)) begin
            match_v20 = 1'b0;
        end
    endfunction

    // "1.99"
    function automatic logic match_v199(input svlp_pkg::cnt_t i, input logic [7:0] b);
        case (i[1:0])
            2'd0:    match_v199 = (b == 8'h31);
            2'd1:    match_v199 = (b == 8'h2E);
            2'd2:    match_v199 = (b == 8'h39);
            default: match_v199 = (b == 8'h39);
        endcase
        if (i >= svlp_pkg::cnt_t'(4)) begin
            match_v199 = 1'b0;
        end
    endfunction

    // State registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg   <= svlp_pkg::PH_PREFIX;
            fail_reg    <= svlp_pkg::ST_RUN;
            vmatch_reg  <= 2'b11;
            pos_reg     <= '0;
            proto_reg   <= '0;
            soft_reg    <= '0;
            comment_reg <= '0;
            content_reg <= '0;
        end else if (advance) begin
            phase_reg   <= phase_next;
            fail_reg    <= fail_next;
            vmatch_reg  <= vmatch_next;
            pos_reg     <= pos_next;
            proto_reg   <= proto_next;
            soft_reg    <= soft_next;
            comment_reg <= comment_next;
            content_reg <= content_next;
        end
    end

    // Next state and result for the byte at hand
    always_comb begin
        phase_next   = phase_reg;
        fail_next    = fail_reg;
        vmatch_next  = vmatch_reg;
        pos_next     = pos_reg;
        proto_next   = proto_reg;
        soft_next    = soft_reg;
        comment_next = comment_reg;
        content_next = content_reg;
        tag          = svlp_pkg::TAG_IGNORED;
        line_end     = 1'b0;
        closed       = 1'b0;
        result       = '0;

        // Line position and the too-long check
        if (pos_reg == svlp_pkg::MAX_CNT) begin
            if (fail_reg == svlp_pkg::ST_RUN) begin
                fail_next = svlp_pkg::ST_TOO_LONG;
            end
        end else begin
            pos_next = pos_reg + svlp_pkg::cnt_t'(1);
        end

        if (item.data_byte == svlp_pkg::CH_LF) begin
            tag      = svlp_pkg::TAG_LF;
            line_end = 1'b1;
        end else begin
            case (phase_reg)
                svlp_pkg::PH_PREFIX: begin
                    if (content_reg < svlp_pkg::cnt_t'(4) &&
                        item.data_byte == prefix_char(content_reg[1:0])) begin
                        tag = svlp_pkg::TAG_PREFIX;
                        if (content_reg == svlp_pkg::cnt_t'(3)) begin
                            phase_next = svlp_pkg::PH_PROTO;
                        end
                    end else begin
                        if (fail_next == svlp_pkg::ST_RUN) begin
                            fail_next = svlp_pkg::ST_BAD_PREFIX;
                        end
                        phase_next = svlp_pkg::PH_REJECT;
                        tag = (item.data_byte == svlp_pkg::CH_CR) ?
                              svlp_pkg::TAG_CR : svlp_pkg::TAG_IGNORED;
                    end
                end
                svlp_pkg::PH_PROTO: begin
                    if (item.data_byte == svlp_pkg::CH_DASH) begin
                        tag        = svlp_pkg::TAG_DASH;
                        phase_next = svlp_pkg::PH_SOFT;
                    end else begin
                        tag = svlp_pkg::TAG_PROTO;
                        if (!match_v20(proto_reg, item.data_byte)) begin
                            vmatch_next[0] = 1'b0;
                        end
                        if (!match_v199(proto_reg, item.data_byte)) begin
                            vmatch_next[1] = 1'b0;
                        end
                        proto_next = sat_inc(proto_reg);
                    end
                end
                svlp_pkg::PH_SOFT: begin
                    if (item.data_byte == svlp_pkg::CH_CR) begin
                        tag        = svlp_pkg::TAG_CR;
                        phase_next = svlp_pkg::PH_TAIL;
                    end else if (item.data_byte == svlp_pkg::CH_SPACE) begin
                        tag        = svlp_pkg::TAG_SPACE;
                        phase_next = svlp_pkg::PH_COMMENT;
                    end else begin
                        tag       = svlp_pkg::TAG_SOFTWARE;
                        soft_next = sat_inc(soft_reg);
                    end
                end
                svlp_pkg::PH_COMMENT: begin
                    if (item.data_byte == svlp_pkg::CH_CR) begin
                        tag        = svlp_pkg::TAG_CR;
                        phase_next = svlp_pkg::PH_TAIL;
                    end else begin
                        tag          = svlp_pkg::TAG_COMMENT;
                        comment_next = sat_inc(comment_reg);
                    end
                end
                default: begin
                    tag = (item.data_byte == svlp_pkg::CH_CR) ?
                          svlp_pkg::TAG_CR : svlp_pkg::TAG_IGNORED;
                end
            endcase
        end

        // Line length leaves out CR and LF
        if (tag != svlp_pkg::TAG_CR && tag != svlp_pkg::TAG_LF) begin
            content_next = sat_inc(content_reg);
        end

        if (item.last_byte) begin
            line_end = 1'b1;
        end

        result.field_tag = tag;

        // Verdict at the end of the line, then start afresh
        if (line_end) begin
            closed = (phase_next == svlp_pkg::PH_SOFT) ||
                     (phase_next == svlp_pkg::PH_COMMENT) ||
                     (phase_next == svlp_pkg::PH_TAIL);
            result.line_done  = 1'b1;
            result.version_ok = closed &&
                ((vmatch_next[0] && proto_next == svlp_pkg::cnt_t'(3)) ||
                 (vmatch_next[1] && proto_next == svlp_pkg::cnt_t'(4)));
            if (fail_next != svlp_pkg::ST_RUN) begin
                result.line_status = fail_next;
            end else if (phase_next == svlp_pkg::PH_PREFIX ||
                         phase_next == svlp_pkg::PH_REJECT) begin
                result.line_status = svlp_pkg::ST_BAD_PREFIX;
            end else if (phase_next == svlp_pkg::PH_PROTO) begin
                result.line_status = svlp_pkg::ST_NO_DASH;
            end else begin
                result.line_status = svlp_pkg::ST_OK;
            end
            result.protocol_len = svlp_pkg::len8(proto_next);
            result.software_len = svlp_pkg::len8(soft_next);
            result.comment_len  = svlp_pkg::len8(comment_next);
            result.line_len     = svlp_pkg::len8(content_next);

            phase_next   = svlp_pkg::PH_PREFIX;
            fail_next    = svlp_pkg::ST_RUN;
            vmatch_next  = 2'b11;
            pos_next     = '0;
            proto_next   = '0;
            soft_next    = '0;
            comment_next = '0;
            content_next = '0;
        end
    end

    // A finished line always leaves the state cleared
    a_clear_after_end: assert property (@(posedge aclk) disable iff (!aresetn)
        advance && line_end |=> pos_reg == '0 && content_reg == '0 &&
                                phase_reg == svlp_pkg::PH_PREFIX)
        else $error("parser state not cleared after line end");

    // Field counts never run past the line position
    a_counts_bounded: assert property (@(posedge aclk) disable iff (!aresetn)
        proto_reg <= pos_reg && soft_reg <= pos_reg && comment_reg <= pos_reg)
        else $error("field count exceeds line position");

endmodule

// ----- design/ssh_version_line_parser.sv -----
// ----------------------------------------------------------------------------
// SSH version line parser
// Tags each byte of an SSH banner line and reports a verdict at line end.
// ----------------------------------------------------------------------------
// Usage:
//   Bytes of a banner line enter on the s_ channel, one item per byte; s_tlast
//   ends a line that carries no LF, an LF byte always ends one. Every byte
//   yields one item on the m_ channel: m_tuser tags the byte's part of the
//   line and m_tlast marks the byte that ended it. On that item m_tdata
//   carries the status, the version flag (2.0 or 1.99) and the protocol,
//   software, comment and line lengths; on other items m_tdata is zero.
//   A byte taken into the input register passes through the parser into the
//   output register when that register is free or being drained. Throughput:
//   one item per cycle while m_tready stays high, set by the loop through the phase and counter registers.
//   An input register and an output register part the two sides, so a new
//   byte is taken while the previous result waits; when m_tready is held low
//   both registers fill and s_tready drops, and nothing is lost.
//   Reset (aresetn low, synchronous) empties both registers and returns the
//   parser to the start of a line.
// ----------------------------------------------------------------------------
module ssh_version_line_parser (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] data_byte
    input  logic        s_tlast,   // last_byte
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [39:0] m_tdata,   // [2:0] line_status, [3] version_ok,
                                   // [11:4] protocol_len, [19:12] software_len,
                                   // [27:20] comment_len, [35:28] line_len,
                                   // [39:36] zero
    output logic        m_tlast,   // line_done
    output logic [3:0]  m_tuser    // field_tag
);

    logic               item_valid;
    logic               advance;
    svlp_pkg::in_item_t item;
    svlp_pkg::result_t  result;
    logic               m_tvalid_reg;
    svlp_pkg::result_t  res_reg;

    // Move a byte through when the output register is free or being drained
    assign advance = item_valid && (!m_tvalid_reg || m_tready);

    svlp_in_reg u_in_reg (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s_tlast    (s_tlast),
        .take       (advance),
        .item_valid (item_valid),
        .item       (item)
    );

    svlp_parser u_parser (
        .aclk    (aclk),
        .aresetn (aresetn),
        .advance (advance),
        .item    (item),
        .result  (result)
    );

    // Output register occupancy
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (advance) begin
            m_tvalid_reg <= 1'b1;
        end else if (m_tready) begin
            m_tvalid_reg <= 1'b0;
        end
    end

    // Output payload
    always_ff @(posedge aclk) begin
        if (advance) begin
            res_reg <= result;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tuser  = res_reg.field_tag;
    assign m_tlast  = res_reg.line_done;
    assign m_tdata  = {4'b0000, res_reg.line_len, res_reg.comment_len,
                       res_reg.software_len, res_reg.protocol_len,
                       res_reg.version_ok, res_reg.line_status};

    // Verdict fields stay zero on items that do not end a line
    a_mid_line_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tlast |-> m_tdata == '0)
        else $error("verdict fields set on a mid-line item");

    // A finished line always carries a real status
    a_done_status: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tlast |-> m_tdata[2:0] != svlp_pkg::ST_RUN)
        else $error("line end reported as in progress");

    // A matched version needs the dash, so the prefix was good
    a_version_status: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tdata[3] |->
            m_tdata[2:0] == svlp_pkg::ST_OK || m_tdata[2:0] == svlp_pkg::ST_TOO_LONG)
        else $error("version flagged on a rejected line");

    // An LF byte always ends its line
    a_lf_ends: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser == svlp_pkg::TAG_LF |-> m_tlast)
        else $error("LF item without line end");

endmodule

// ----- bench/ssh_version_line_parser_test.sv -----
// ----------------------------------------------------------------------------
// SSH version line parser testbench
// Feeds banner lines one byte per item and checks every result item.
// A short directed part is followed by random lines: well-formed banners,
// oversize lines, broken prefixes, lines without a dash and raw noise. They
// are run under four idling patterns. A local line predictor models the
// parser, and each result is compared field by field with the oldest
// prediction.
// ----------------------------------------------------------------------------
module ssh_version_line_parser_test;

    import svlp_pkg::*;

    // Text constants, first character in the top byte
    localparam logic [31:0] SSH_PREFIX    = "SSH-";
    localparam logic [23:0] V20_TEXT      = "2.0";
    localparam logic [31:0] V199_TEXT     = "1.99";
    localparam logic [39:0] VERSION_CHARS = "012.9";
    localparam int          PHASE_BYTES   = 375;

    logic        aclk = 1'b0;
    logic        aresetn;
    logic        s_tvalid;
    logic        s_tready;
    logic [7:0]  s_tdata;
    logic        s_tlast;
    logic        m_tvalid;
    logic        m_tready;
    logic [39:0] m_tdata;
    logic        m_tlast;
    logic [3:0]  m_tuser;

    ssh_version_line_parser dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast),
        .m_tuser  (m_tuser)
    );

    always #5 aclk = ~aclk;

    // Stimulus and expectation stores
    in_item_t pending_bytes[$];
    result_t  expected_byte_results[$];
    in_item_t next_byte;
    result_t  want;
    logic     byte_taken = 1'b0;
    int       send_idle_pct = 0;
    int       recv_stall_pct = 0;
    int       queued_bytes = 0;
    int       bytes_accepted = 0;
    int       lines_done = 0;
    int       version_hits = 0;
    int       status_seen [0:4] = '{default: 0};
    int       mismatch_count = 0;

    // Predictor state for the line in progress
    cnt_t     line_pos;
    phase_t   parse_ph;
    status_t  fail_code;
    logic [1:0] vmatch;
    cnt_t     proto_cnt;
    cnt_t     soft_cnt;
    cnt_t     comm_cnt;
    cnt_t     content_cnt;

    function automatic cnt_t sat_up(input cnt_t v);
        return (v >= MAX_CNT) ? MAX_CNT : cnt_t'(v + 1'b1);
    endfunction

    function automatic logic [7:0] clamp_len(input cnt_t v);
        return (int'(v) > 255) ? 8'hFF : 8'(v);
    endfunction

    function automatic void start_new_line();
        line_pos    = '0;
        parse_ph    = PH_PREFIX;
        fail_code   = ST_RUN;
        vmatch      = 2'b11;
        proto_cnt   = '0;
        soft_cnt    = '0;
        comm_cnt    = '0;
        content_cnt = '0;
    endfunction

    // Tag one byte, and give the line verdict when it ends the line
    function automatic result_t predict_banner_byte(input logic [7:0] b, input logic last);
        result_t r;
        logic    line_end;
        logic    closed;
        status_t st;
        int      idx;
        r        = '0;
        r.field_tag = TAG_IGNORED;
        line_end = last;
        if (line_pos >= MAX_CNT && fail_code == ST_RUN)
            fail_code = ST_TOO_LONG;
        line_pos = sat_up(line_pos);

        if (b == CH_LF) begin
            r.field_tag = TAG_LF;
            line_end    = 1'b1;
        end else begin
            case (parse_ph)
                PH_PREFIX: begin
                    idx = int'(content_cnt);
                    if (idx < 4 && b == SSH_PREFIX[8*(3-idx) +: 8]) begin
                        r.field_tag = TAG_PREFIX;
                        if (idx == 3)
                            parse_ph = PH_PROTO;
                    end else begin
                        if (fail_code == ST_RUN)
                            fail_code = ST_BAD_PREFIX;
                        parse_ph = PH_REJECT;
                        if (b == CH_CR)
                            r.field_tag = TAG_CR;
                    end
                end
                PH_PROTO: begin
                    if (b == CH_DASH) begin
                        r.field_tag = TAG_DASH;
                        parse_ph    = PH_SOFT;
                    end else begin
                        r.field_tag = TAG_PROTO;
                        idx = int'(proto_cnt);
                        // track both accepted versions character by character
                        if (idx >= 3)
                            vmatch[0] = 1'b0;
                        else if (V20_TEXT[8*(2-idx) +: 8] != b)
                            vmatch[0] = 1'b0;
                        if (idx >= 4)
                            vmatch[1] = 1'b0;
                        else if (V199_TEXT[8*(3-idx) +: 8] != b)
                            vmatch[1] = 1'b0;
                        proto_cnt = sat_up(proto_cnt);
                    end
                end
                PH_SOFT: begin
                    if (b == CH_CR) begin
                        r.field_tag = TAG_CR;
                        parse_ph    = PH_TAIL;
                    end else if (b == CH_SPACE) begin
                        r.field_tag = TAG_SPACE;
                        parse_ph    = PH_COMMENT;
                    end else begin
                        r.field_tag = TAG_SOFTWARE;
                        soft_cnt    = sat_up(soft_cnt);
                    end
                end
                PH_COMMENT: begin
                    if (b == CH_CR) begin
                        r.field_tag = TAG_CR;
                        parse_ph    = PH_TAIL;
                    end else begin
                        r.field_tag = TAG_COMMENT;
                        comm_cnt    = sat_up(comm_cnt);
                    end
                end
                default: begin
                    if (b == CH_CR)
                        r.field_tag = TAG_CR;
                end
            endcase
        end

        if (r.field_tag != TAG_CR && r.field_tag != TAG_LF)
            content_cnt = sat_up(content_cnt);

        // verdict: first failure wins, then the phase reached
        if (line_end) begin
            closed = (parse_ph == PH_SOFT || parse_ph == PH_COMMENT || parse_ph == PH_TAIL);
            if (fail_code != ST_RUN)
                st = fail_code;
            else if (parse_ph == PH_PREFIX || parse_ph == PH_REJECT)
                st = ST_BAD_PREFIX;
            else if (parse_ph == PH_PROTO)
                st = ST_NO_DASH;
            else
                st = ST_OK;
            r.line_done    = 1'b1;
            r.line_status  = st;
            r.version_ok   = closed && ((vmatch[0] && proto_cnt == 3) ||
                                        (vmatch[1] && proto_cnt == 4));
            r.protocol_len = clamp_len(proto_cnt);
            r.software_len = clamp_len(soft_cnt);
            r.comment_len  = clamp_len(comm_cnt);
            r.line_len     = clamp_len(content_cnt);
            start_new_line();
        end
        return r;
    endfunction

    // Stimulus helpers
    task automatic queue_byte(input logic [7:0] b, input logic last);
        in_item_t it;
        it.data_byte = b;
        it.last_byte = last;
        pending_bytes.push_back(it);
        queued_bytes++;
    endtask

    task automatic queue_text(input string s);
        for (int i = 0; i < s.len(); i++)
            queue_byte(s[i], 1'b0);
    endtask

    // Random byte avoiding three delimiters, printable half the time
    function automatic logic [7:0] text_byte(input logic [7:0] x0, x1, x2);
        logic [7:0] b;
        do begin
            if ($urandom_range(1))
                b = 8'($urandom_range(8'h20, 8'h7E));
            else
                b = 8'($urandom);
        end while (b == x0 || b == x1 || b == x2);
        return b;
    endfunction

    // Mostly near misses of the accepted versions
    function automatic logic [7:0] proto_byte();
        if ($urandom_range(9) < 7)
            return VERSION_CHARS[8*$urandom_range(4) +: 8];
        return text_byte(CH_DASH, CH_LF, CH_LF);
    endfunction

    task automatic gen_banner_line();
        int         roll;
        int         n;
        int         k;
        int         stretch;
        int         target;
        int         vpick;
        int         ending;
        logic [7:0] b;
        logic       last;
        roll = $urandom_range(99);

        // raw noise, ended by tlast
        if (roll >= 88) begin
            n = $urandom_range(1, 8);
            for (k = 0; k < n; k++)
                queue_byte(8'($urandom), (k == n - 1) || ($urandom_range(7) == 0));
            return;
        end

        // prefix cut short by a wrong byte
        if (roll >= 81) begin
            n = $urandom_range(0, 3);
            for (k = 0; k < n; k++)
                queue_byte(SSH_PREFIX[8*(3-k) +: 8], 1'b0);
            b    = 8'($urandom);
            last = $urandom_range(1);
            queue_byte(b, last);
            if (!last && b != CH_LF)
                queue_byte(CH_LF, 1'b0);
            return;
        end

        queue_text("SSH-");

        // line ending inside the protocol field
        if (roll >= 75) begin
            n = $urandom_range(0, 5);
            for (k = 0; k < n; k++)
                queue_byte(proto_byte(), 1'b0);
            if (n > 0 && $urandom_range(1))
                queue_byte(proto_byte(), 1'b1);
            else
                queue_byte(CH_LF, 1'b0);
            return;
        end

        // well-formed banner; oversize lines stretch one field past MAX_LINE
        stretch = (roll >= 65) ? $urandom_range(1, 3) : 0;
        target  = $urandom_range(250, 300);
        vpick   = $urandom_range(9);
        if (stretch == 1) begin
            for (k = 0; k < target; k++)
                queue_byte(proto_byte(), 1'b0);
        end else if (vpick < 4) begin
            queue_text("2.0");
        end else if (vpick < 7) begin
            queue_text("1.99");
        end else begin
            n = $urandom_range(0, 5);
            for (k = 0; k < n; k++)
                queue_byte(proto_byte(), 1'b0);
        end
        queue_byte(CH_DASH, 1'b0);

        n = (stretch == 2) ? target : $urandom_range(0, 12);
        for (k = 0; k < n; k++)
            queue_byte(text_byte(CH_SPACE, CH_CR, CH_LF), 1'b0);

        if (stretch == 3 || $urandom_range(1)) begin
            queue_byte(CH_SPACE, 1'b0);
            n = (stretch == 3) ? target : $urandom_range(0, 10);
            for (k = 0; k < n; k++)
                queue_byte(text_byte(CH_CR, CH_LF, CH_LF), 1'b0);
        end

        ending = $urandom_range(10);
        if (ending <= 6) begin
            queue_byte(CH_CR, 1'b0);
            queue_byte(CH_LF, 1'b0);
        end else if (ending == 7) begin
            queue_byte(CH_CR, 1'b0);
            n = $urandom_range(1, 3);
            for (k = 0; k < n; k++)
                queue_byte(text_byte(CH_LF, CH_LF, CH_LF), 1'b0);
            queue_byte(CH_LF, 1'b0);
        end else if (ending == 8) begin
            queue_byte(CH_LF, 1'b0);
        end else if (ending == 9) begin
            queue_byte(CH_CR, 1'b1);
        end else begin
            queue_byte(text_byte(CH_CR, CH_LF, CH_LF), 1'b1);
        end
    endtask

    task automatic check_field(input string name, input logic [7:0] exp_v, act_v);
        if (exp_v !== act_v) begin
            $error("%s: expected %0d, got %0d", name, exp_v, act_v);
            mismatch_count++;
        end
    endtask

    // Sender side: predict each accepted item
    always @(posedge aclk) begin
        if (aresetn && s_tvalid && s_tready) begin
            expected_byte_results.push_back(predict_banner_byte(s_tdata, s_tlast));
            bytes_accepted++;
            byte_taken = 1'b1;
        end
    end

    // Sender and receiver drive at the falling edge
    always @(negedge aclk) begin
        if (aresetn) begin
            m_tready <= ($urandom_range(99) >= recv_stall_pct);
            if (byte_taken || !s_tvalid) begin
                byte_taken = 1'b0;
                if (pending_bytes.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
                    next_byte = pending_bytes.pop_front();
                    s_tvalid <= 1'b1;
                    s_tdata  <= next_byte.data_byte;
                    s_tlast  <= next_byte.last_byte;
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // Result side: compare with the oldest prediction
    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) begin
            if (expected_byte_results.size() == 0) begin
                $error("result item with no byte outstanding: tag %0d", m_tuser);
                mismatch_count++;
            end else begin
                want = expected_byte_results.pop_front();
                check_field("field_tag", want.field_tag, m_tuser);
                check_field("line_done", want.line_done, m_tlast);
                check_field("line_status", want.line_status, m_tdata[2:0]);
                check_field("version_ok", want.version_ok, m_tdata[3]);
                check_field("protocol_len", want.protocol_len, m_tdata[11:4]);
                check_field("software_len", want.software_len, m_tdata[19:12]);
                check_field("comment_len", want.comment_len, m_tdata[27:20]);
                check_field("line_len", want.line_len, m_tdata[35:28]);
                if (want.line_done) begin
                    lines_done++;
                    status_seen[want.line_status]++;
                    if (want.version_ok)
                        version_hits++;
                end
            end
        end
    end

    // Run: reset, then four idling phases
    initial begin
        int first;
        aresetn  = 1'b0;
        s_tvalid = 1'b0;
        s_tdata  = '0;
        s_tlast  = 1'b0;
        m_tready = 1'b0;
        start_new_line();
        repeat (10) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        for (int ph = 0; ph < 4; ph++) begin
            case (ph)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 82; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 82; end
                default: begin send_idle_pct = 11; recv_stall_pct = 11; end
            endcase
            if (ph == 0) begin
                // every tag, version 2.0, a byte after CR, the highest byte value
                queue_text("SSH-2.0-A B");
                queue_byte(CH_CR, 1'b0);
                queue_byte(8'hFF, 1'b0);
                queue_byte(CH_LF, 1'b0);
                // version 1.99, line ended by tlast
                queue_text("SSH-1.99-");
                queue_byte(8'h00, 1'b1);
                // prefix mismatch on CR, line ends before the prefix is complete
                queue_text("S");
                queue_byte(CH_CR, 1'b1);
                // CR inside the protocol field, no dash
                queue_text("SSH-");
                queue_byte(CH_CR, 1'b1);
            end
            first = queued_bytes;
            while (queued_bytes - first < PHASE_BYTES)
                gen_banner_line();
            while (pending_bytes.size() != 0 || s_tvalid || expected_byte_results.size() != 0)
                @(negedge aclk);
        end

        repeat (4) @(posedge aclk);
        $display("summary: %0d bytes over four idling patterns, %0d lines", bytes_accepted,
                 lines_done);
        $display("summary: %0d ok, %0d bad prefix, %0d no dash, %0d too long, %0d good version",
                 status_seen[ST_OK], status_seen[ST_BAD_PREFIX], status_seen[ST_NO_DASH],
                 status_seen[ST_TOO_LONG], version_hits);
        if (mismatch_count == 0)
            $display("ssh_version_line_parser_test: done, clean");
        else
            $display("ssh_version_line_parser_test: done, errors");
        $finish;
    end

    // Watchdog
    initial begin
        #2000000;
        $display("ssh_version_line_parser_test: done, errors");
        $finish;
    end

endmodule
